### hw/rtl/frs_pkg.sv
// Shared constants, types and state encoding for the fitness rank sorter.
package frs_pkg;

  localparam int MAX_ITEMS   = 32;
  localparam int STORE_DEPTH = (MAX_ITEMS < 32) ? MAX_ITEMS : 32;
  localparam int FIT_W       = 32;
  localparam int IDX_W       = 5;
  localparam int CNT_W       = 6;

  // Running best candidate that travels down the cell chain.
  typedef struct packed {
    logic                    have;
    logic signed [FIT_W-1:0] value;
    logic [IDX_W-1:0]        idx;
  } token_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic             load;
    logic             mark;
    logic             clear;
    logic [IDX_W-1:0] sel_idx;
    logic [CNT_W-1:0] count;
  } cell_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

### hw/rtl/fitness_rank_sort.sv
// Top level of the fitness rank sorter: cell chain plus batch sequencer.
// Loading takes one request per cycle while not busy; a request marked last starts the ranking.
// Each rank is one pass of the running best through the cell chain, after which the
// winner is registered as the result and marked taken.
// A batch keeps busy high after its last request until its last result is registered.
// Synchronous active-low reset clears count, flags and sequencer; store contents are not cleared.
module fitness_rank_sort (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [frs_pkg::FIT_W-1:0]   in_fitness,
  input  logic                               in_last,
  output logic                               out_valid,
  output logic [frs_pkg::IDX_W-1:0]          out_offspring_index,
  output logic                               out_overflow,
  output logic                               out_last_result
);

  localparam int D = frs_pkg::STORE_DEPTH;

  // Sequencer state.
  frs_pkg::state_t               state_r;
  frs_pkg::state_t               state_nxt;
  logic [frs_pkg::CNT_W-1:0]     count_r;
  logic [frs_pkg::CNT_W-1:0]     count_nxt;
  logic                          ovf_r;
  logic                          ovf_nxt;
  logic [frs_pkg::CNT_W-1:0]     scan_cnt_r;
  logic [frs_pkg::CNT_W-1:0]     scan_cnt_nxt;
  logic [frs_pkg::CNT_W-1:0]     rank_r;
  logic [frs_pkg::CNT_W-1:0]     rank_nxt;

  // Result registers.
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic [frs_pkg::IDX_W-1:0]     out_idx_r;
  logic [frs_pkg::IDX_W-1:0]     out_idx_nxt;
  logic                          out_ovf_r;
  logic                          out_ovf_nxt;
  logic                          out_last_r;
  logic                          out_last_nxt;

  logic                          accept;
  logic                          room;
  logic                          scan_done;
  logic                          last_rank;
  frs_pkg::cell_ctrl_t           ctrl;
  frs_pkg::token_t               chain_in  [D];
  frs_pkg::token_t               chain_out [D];

  // A request is taken only between batches; ranking holds busy high.
  assign busy   = (state_r != frs_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign room   = (count_r < frs_pkg::CNT_W'(D));

  // The token at the chain end reflects a full pass once the scan counter, restarted
  // whenever the taken flags change, reaches D.
  assign scan_done = (state_r == frs_pkg::ST_SCAN) && (scan_cnt_r == frs_pkg::CNT_W'(D));
  assign last_rank = ((rank_r + frs_pkg::CNT_W'(1)) == count_r);

  // The chain: cell 0 starts every pass with an empty candidate, and each cell
  // registers the better of its own entry and the candidate handed to it.
  genvar g;
  generate
    for (g = 0; g < D; g++) begin : g_cell
      if (g == 0) begin : g_head
        assign chain_in[g] = '0;
      end else begin : g_link
        assign chain_in[g] = chain_out[g-1];
      end

      frs_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_idx   (frs_pkg::IDX_W'(g)),
        .ctrl       (ctrl),
        .wr_fitness (in_fitness),
        .tok_in     (chain_in[g]),
        .tok_out    (chain_out[g])
      );
    end
  endgenerate

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      frs_pkg::ST_IDLE: begin
        if (accept && in_last) begin
          state_nxt = frs_pkg::ST_SCAN;
        end
      end
      frs_pkg::ST_SCAN: begin
        if (scan_done && last_rank) begin
          state_nxt = frs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = frs_pkg::ST_IDLE;
    endcase
  end

  // Output and datapath control. While loading, the select index addresses the
  // next free cell; while ranking, it names the winner to be marked taken.
  always_comb begin
    ctrl.load     = 1'b0;
    ctrl.mark     = 1'b0;
    ctrl.clear    = 1'b0;
    ctrl.sel_idx  = count_r[frs_pkg::IDX_W-1:0];
    ctrl.count    = count_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    scan_cnt_nxt  = '0;
    rank_nxt      = rank_r;
    out_valid_nxt = 1'b0;
    out_idx_nxt   = out_idx_r;
    out_ovf_nxt   = out_ovf_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      frs_pkg::ST_IDLE: begin
        if (accept) begin
          if (room) begin
            ctrl.load = 1'b1;
            count_nxt = count_r + frs_pkg::CNT_W'(1);
          end else begin
            // The store is full, so the value is dropped and the batch is flagged.
            ovf_nxt = 1'b1;
          end
        end
      end
      frs_pkg::ST_SCAN: begin
        ctrl.sel_idx = chain_out[D-1].idx;
        if (scan_done) begin
          ctrl.mark     = 1'b1;
          out_valid_nxt = 1'b1;
          out_idx_nxt   = chain_out[D-1].idx;
          out_ovf_nxt   = ovf_r;
          out_last_nxt  = last_rank;
          rank_nxt      = rank_r + frs_pkg::CNT_W'(1);
          if (last_rank) begin
            // End of batch: ready for the next one.
            ctrl.clear = 1'b1;
            count_nxt  = '0;
            ovf_nxt    = 1'b0;
            rank_nxt   = '0;
          end
        end else begin
          scan_cnt_nxt = scan_cnt_r + frs_pkg::CNT_W'(1);
        end
      end
      default: begin
        ctrl.clear = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= frs_pkg::ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      scan_cnt_r  <= '0;
      rank_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      rank_r      <= rank_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_idx_r  <= out_idx_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_offspring_index = out_idx_r;
  assign out_overflow        = out_ovf_r;
  assign out_last_result     = out_last_r;

endmodule

### hw/rtl/frs_cell.sv
// One store cell: holds a fitness entry and its taken flag and passes the running best on.
module frs_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [frs_pkg::IDX_W-1:0]      cell_idx,
  input  frs_pkg::cell_ctrl_t            ctrl,
  input  logic signed [frs_pkg::FIT_W-1:0] wr_fitness,
  input  frs_pkg::token_t                tok_in,
  output frs_pkg::token_t                tok_out
);

  logic signed [frs_pkg::FIT_W-1:0] fit_r;
  logic                             taken_r;
  logic                             taken_nxt;
  frs_pkg::token_t                  tok_r;
  frs_pkg::token_t                  tok_nxt;
  logic                             sel_hit;
  logic                             own_ok;
  logic                             take;

  assign sel_hit = (ctrl.sel_idx == cell_idx);

  // Only entries written in this batch take part, and each one only until emitted.
  assign own_ok = ({1'b0, cell_idx} < ctrl.count) && !taken_r;

  // Strictly greater replaces, so the lower index wins a tie.
  assign take = own_ok && (!tok_in.have || (fit_r > tok_in.value));

  always_comb begin
    tok_nxt = tok_in;
    if (take) begin
      tok_nxt.have  = 1'b1;
      tok_nxt.value = fit_r;
      tok_nxt.idx   = cell_idx;
    end
  end

  always_comb begin
    taken_nxt = taken_r;
    if (ctrl.clear) begin
      taken_nxt = 1'b0;
    end else if (ctrl.mark && sel_hit) begin
      taken_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r  <= 1'b0;
      tok_r    <= '0;
    end else begin
      taken_r  <= taken_nxt;
      tok_r    <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load && sel_hit) begin
      fit_r <= wr_fitness;
    end
  end

  assign tok_out = tok_r;

endmodule
